// File: rtl/battery_percent_stable_filter_macros.svh
// Assertion macros shared by the battery percentage filter RTL.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef BATTERY_PERCENT_STABLE_FILTER_MACROS_SVH
`define BATTERY_PERCENT_STABLE_FILTER_MACROS_SVH

// same-cycle implication, disabled during reset
`define BPSF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define BPSF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bpsf_pkg.sv
// Shared widths, constants, register codes and divider interface types
// for the battery percentage filter. No dependencies.
`default_nettype none

package bpsf_pkg;

    // field widths
    localparam int unsigned SAMPLE_W   = 10;
    localparam int unsigned PCT_W      = 7;
    localparam int unsigned MV_W       = 13;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned OUT_DATA_W = 16;
    localparam int unsigned IN_PAD_W   = IN_DATA_W - SAMPLE_W;
    localparam int unsigned OUT_PAD_W  = OUT_DATA_W - (2 * PCT_W + 1);

    // arithmetic widths (tenths of a millivolt)
    localparam int unsigned V_W   = 16;                 // sample*42 <= 42966
    localparam int unsigned TMV_W = 17;                 // mV*10 <= 81910
    localparam int unsigned DIV_W = TMV_W + 1;          // 2*(F-E)
    localparam int unsigned Q_W   = PCT_W;              // quotient <= 100
    localparam int unsigned NUM_W = DIV_W + Q_W - 1;    // 200*(v-E)+(F-E)
    localparam int unsigned STEP_W = 3;

    // scale factors
    localparam logic [V_W-1:0]   COUNTS_TO_TENTHS = V_W'(42);
    localparam logic [TMV_W-1:0] MV_TO_TENTHS     = TMV_W'(10);
    localparam logic [NUM_W-1:0] PCT_SCALE2       = NUM_W'(200);
    localparam logic [PCT_W-1:0] PCT_FULL         = PCT_W'(100);
    localparam logic [PCT_W-1:0] PCT_ZERO         = PCT_W'(0);

    // register map and reset values
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_MV = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FULL_MV  = CFG_IDX_W'(1);
    localparam logic [MV_W-1:0]      EMPTY_MV_RST = MV_W'(3300);
    localparam logic [MV_W-1:0]      FULL_MV_RST  = MV_W'(4200);

    // parameter defaults
    localparam int unsigned WINDOW_LENGTH_DEF  = 5;
    localparam int unsigned LOW_RUN_LENGTH_DEF = 5;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DIV_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

// File: rtl/bpsf_div.sv
// Restoring serial divider, one quotient bit per cycle, MSB first.
// Depends on bpsf_pkg. Quotient must fit in Q_W bits.
`default_nettype none

module bpsf_div
    import bpsf_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic [NUM_W-1:0]  r_rem, n_rem;
    logic [NUM_W-1:0]  r_dsh, n_dsh;
    logic [Q_W-1:0]    r_quot, n_quot;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;

    always_comb begin
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_quot = r_quot;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_rem  = i_req.num;
            n_dsh  = {i_req.den, (Q_W - 1)'(0)};
            n_quot = '0;
            n_cnt  = STEP_W'(Q_W - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_rem >= r_dsh) begin
                n_rem  = r_rem - r_dsh;
                n_quot = {r_quot[Q_W-2:0], 1'b1};
            end else begin
                n_quot = {r_quot[Q_W-2:0], 1'b0};
            end
            n_dsh = r_dsh >> 1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem  <= n_rem;
        r_dsh  <= n_dsh;
        r_quot <= n_quot;
        r_cnt  <= n_cnt;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

`default_nettype wire

// File: rtl/battery_percent_stable_filter.sv
// Battery state-of-charge filter: each transfer on the slave stream is one 10-bit
// converter reading (4.2 mV per count). The block maps it linearly between the
// empty and full voltages to a percentage 0..100 rounded half up, debounces it
// (the filtered value moves only when the new value matches the previous
// WINDOW_LENGTH-1 values) and drops the supply_ok flag after LOW_RUN_LENGTH
// consecutive readings below the empty voltage. One result transfer per input.
// A reading is taken only in the idle state, after the last one has left the
// finish state. One that needs the division waits on the 7-step serial divider;
// one clamped to 0 or 100 skips it. A new reading is taken while a result waits
// in the output register. Configuration writes are always taken (ready held high).
// Depends on bpsf_pkg, bpsf_div and battery_percent_stable_filter_macros.svh.
`default_nettype none

module battery_percent_stable_filter
    import bpsf_pkg::*;
#(
    parameter int unsigned WINDOW_LENGTH  = WINDOW_LENGTH_DEF,   // 2..16
    parameter int unsigned LOW_RUN_LENGTH = LOW_RUN_LENGTH_DEF   // 1..7
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [MV_W-1:0]       i_cfg_data,
    // input stream
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,  // [9:0] adc_sample, rest zero
    // result stream
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata   // [6:0] raw_percent,
                                                        // [13:7] filtered_percent,
                                                        // [14] supply_ok, [15] zero
);

    localparam int unsigned HIST_LEN = WINDOW_LENGTH - 1;
    localparam int unsigned LR_W     = $clog2(LOW_RUN_LENGTH + 1);
    localparam logic [LR_W-1:0] LOW_RUN_MAX = LR_W'(LOW_RUN_LENGTH);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;   // waiting for a reading
    localparam logic [1:0] ST_CALC = 2'd1;   // scale, clamp checks, start divide
    localparam logic [1:0] ST_DIV  = 2'd2;   // divider running
    localparam logic [1:0] ST_FIN  = 2'd3;   // update filter state, load output

    logic [1:0]          r_state, n_state;
    logic [MV_W-1:0]     r_empty_mv;
    logic [MV_W-1:0]     r_full_mv;
    logic [SAMPLE_W-1:0] r_sample;
    logic [PCT_W-1:0]    r_pct, n_pct;
    logic                r_low, n_low;

    logic [PCT_W-1:0]    r_hist [HIST_LEN];
    logic [PCT_W-1:0]    r_stable;
    logic                r_primed;
    logic [LR_W-1:0]     r_low_cnt, n_low_cnt;

    logic                r_out_valid;
    logic [PCT_W-1:0]    r_out_raw;
    logic [PCT_W-1:0]    r_out_filt;
    logic                r_out_pg;

    t_div_req            w_div_req;
    t_div_rsp            w_div_rsp;

    logic                w_in_xfer;
    logic                w_out_xfer;
    logic                w_fin_go;
    logic                w_all_equal;
    logic [PCT_W-1:0]    w_stable_nxt;

    // scaled quantities, all in tenths of a millivolt
    logic [V_W-1:0]      w_v;
    logic [TMV_W-1:0]    w_v_ext;
    logic [TMV_W-1:0]    w_e;
    logic [TMV_W-1:0]    w_f;
    logic [TMV_W-1:0]    w_span;
    logic [TMV_W-1:0]    w_dv;
    logic                w_special;

    assign w_in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_xfer = o_m_axis_tvalid && i_m_axis_tready;
    // result register free now or emptied this cycle
    assign w_fin_go   = (r_state == ST_FIN) && (!r_out_valid || i_m_axis_tready);

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == ST_IDLE);

    // configuration registers; unknown index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty_mv <= EMPTY_MV_RST;
            r_full_mv  <= FULL_MV_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_EMPTY_MV: r_empty_mv <= i_cfg_data;
                REG_FULL_MV:  r_full_mv  <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_sample <= i_s_axis_tdata[SAMPLE_W-1:0];
        end
    end

    // scaling by constants, then the clamp cases that skip the divider
    assign w_v     = V_W'(r_sample) * COUNTS_TO_TENTHS;
    assign w_v_ext = TMV_W'(w_v);
    assign w_e     = TMV_W'(r_empty_mv) * MV_TO_TENTHS;
    assign w_f     = TMV_W'(r_full_mv) * MV_TO_TENTHS;
    assign w_span  = w_f - w_e;
    assign w_dv    = w_v_ext - w_e;
    assign w_special = (w_f <= w_e) || (w_v_ext <= w_e) || (w_v_ext >= w_f);

    // round half up: (200*(v-E) + span) / (2*span)
    assign w_div_req.start = (r_state == ST_CALC) && !w_special;
    assign w_div_req.num   = NUM_W'(w_dv) * PCT_SCALE2 + NUM_W'(w_span);
    assign w_div_req.den   = {w_span, 1'b0};

    bpsf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        n_pct   = r_pct;
        n_low   = r_low;
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                n_low = (w_v_ext < w_e);
                if (w_special) begin
                    // full not above empty falls in here too
                    n_pct   = (w_f > w_e) ? ((w_v_ext >= w_f) ? PCT_FULL : PCT_ZERO)
                                          : ((w_v_ext >= w_f) ? PCT_FULL : PCT_ZERO);
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_rsp.done) begin
                    n_pct   = w_div_rsp.quot;
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_fin_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_pct <= n_pct;
        r_low <= n_low;
    end

    // debounce: compare against every stored value
    always_comb begin
        w_all_equal = 1'b1;
        for (int i = 0; i < HIST_LEN; i++) begin
            if (r_hist[i] != r_pct) begin
                w_all_equal = 1'b0;
            end
        end
    end

    assign w_stable_nxt = (!r_primed || w_all_equal) ? r_pct : r_stable;

    // saturating run of low readings, cleared by any reading not below empty
    always_comb begin
        if (!r_low) begin
            n_low_cnt = '0;
        end else if (r_low_cnt < LOW_RUN_MAX) begin
            n_low_cnt = r_low_cnt + LR_W'(1);
        end else begin
            n_low_cnt = r_low_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable  <= PCT_ZERO;
            r_primed  <= 1'b0;
            r_low_cnt <= '0;
            for (int i = 0; i < HIST_LEN; i++) begin
                r_hist[i] <= PCT_ZERO;
            end
        end else if (w_fin_go) begin
            r_stable  <= w_stable_nxt;
            r_primed  <= 1'b1;
            r_low_cnt <= n_low_cnt;
            if (!r_primed) begin
                // first reading fills the whole window
                for (int i = 0; i < HIST_LEN; i++) begin
                    r_hist[i] <= r_pct;
                end
            end else begin
                for (int i = 0; i + 1 < HIST_LEN; i++) begin
                    r_hist[i] <= r_hist[i+1];
                end
                r_hist[HIST_LEN-1] <= r_pct;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fin_go) begin
            r_out_valid <= 1'b1;
        end else if (w_out_xfer) begin
            r_out_valid <= 1'b0;
        end
        if (w_fin_go) begin
            r_out_raw  <= r_pct;
            r_out_filt <= w_stable_nxt;
            r_out_pg   <= (n_low_cnt < LOW_RUN_MAX);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {OUT_PAD_W'(0), r_out_pg, r_out_filt, r_out_raw};

    // checks
    `include "battery_percent_stable_filter_macros.svh"

    `BPSF_ASSERT_IMP(a_raw_in_range, o_m_axis_tvalid, r_out_raw <= PCT_FULL, "raw_percent over 100")
    `BPSF_ASSERT_IMP(a_cnt_sat, 1'b1, r_low_cnt <= LOW_RUN_MAX, "low run count past saturation")
    `BPSF_ASSERT_IMP(a_div_done_state, w_div_rsp.done, r_state == ST_DIV, "divider done outside wait")
    `BPSF_ASSERT_NXT(a_fin_loads_out, w_fin_go, o_m_axis_tvalid && r_primed, "result not presented after finish")

endmodule

`default_nettype wire

// File: tb/sv/battery_percent_stable_filter_test.sv
// Self-checking testbench for battery_percent_stable_filter: directed and random
// readings on the sample stream, results checked against an in-bench predictor.
// Depends on bpsf_pkg and the battery_percent_stable_filter RTL.
`default_nettype none

module battery_percent_stable_filter_test
    import bpsf_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HIST_DEPTH  = WINDOW_LENGTH_DEF - 1;
    localparam int unsigned STALL_LIMIT = 2000;   // cycles without any transfer
    localparam int unsigned TAIL_CYCLES = 40;     // settle time after the last result
    localparam int unsigned RANDOM_PHASES = 10;
    localparam int unsigned READINGS_PER_PHASE = 175;

    // indexes outside the register map; writes to them must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

    typedef struct packed {
        logic [PCT_W-1:0] raw_percent;
        logic [PCT_W-1:0] filtered_percent;
        logic             supply_ok;
    } t_charge_report;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [MV_W-1:0]       i_cfg_data;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;   // [9:0] adc_sample, rest zero
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;   // [6:0] raw_percent, [13:7] filtered_percent,
                                             // [14] supply_ok, [15] zero

    battery_percent_stable_filter #(
        .WINDOW_LENGTH  (WINDOW_LENGTH_DEF),
        .LOW_RUN_LENGTH (LOW_RUN_LENGTH_DEF)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // ------------------------------------------------------------------
    // Predictor state: mirror of the registers and of the filter state
    // ------------------------------------------------------------------
    logic [MV_W-1:0]  empty_mv = EMPTY_MV_RST;
    logic [MV_W-1:0]  full_mv  = FULL_MV_RST;
    logic [PCT_W-1:0] pct_history [HIST_DEPTH] = '{default: '0};
    logic [PCT_W-1:0] stable_pct = '0;
    logic             history_primed = 1'b0;
    int unsigned      low_run = 0;

    t_charge_report pending_reports[$];   // expected results, oldest first
    int unsigned    error_count = 0;
    bit             no_gaps = 1'b0;       // set for stretches with no idling

    // Works out the report for one accepted reading and advances the filter state.
    function automatic t_charge_report predict_report(input logic [SAMPLE_W-1:0] sample);
        int unsigned    v;
        int unsigned    e;
        int unsigned    f;
        int unsigned    den;
        logic [PCT_W-1:0] pct;
        bit             run_equal;
        t_charge_report rep;
        v = sample * COUNTS_TO_TENTHS;
        e = empty_mv * MV_TO_TENTHS;
        f = full_mv * MV_TO_TENTHS;
        // linear map in tenths of a millivolt; degenerate window is a plain threshold
        if (f <= e)
            pct = (v >= f) ? PCT_FULL : PCT_ZERO;
        else if (v <= e)
            pct = PCT_ZERO;
        else if (v >= f)
            pct = PCT_FULL;
        else begin
            den = f - e;
            pct = PCT_W'((200 * (v - e) + den) / (2 * den));   // rounded half up
        end
        // debounce: first reading fills the whole history
        if (!history_primed) begin
            foreach (pct_history[i]) pct_history[i] = pct;
            stable_pct = pct;
            history_primed = 1'b1;
        end else begin
            run_equal = 1'b1;
            foreach (pct_history[i]) if (pct_history[i] != pct) run_equal = 1'b0;
            for (int i = 0; i + 1 < HIST_DEPTH; i++) pct_history[i] = pct_history[i + 1];
            pct_history[HIST_DEPTH - 1] = pct;
            if (run_equal) stable_pct = pct;
        end
        // strict below-empty run, saturating
        if (v < e) begin
            if (low_run < LOW_RUN_LENGTH_DEF) low_run++;
        end else begin
            low_run = 0;
        end
        rep.raw_percent      = pct;
        rep.filtered_percent = stable_pct;
        rep.supply_ok        = (low_run >= LOW_RUN_LENGTH_DEF) ? 1'b0 : 1'b1;
        return rep;
    endfunction

    function automatic int unsigned draw_gap();
        return no_gaps ? 0 : $urandom_range(0, 4);
    endfunction

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Counts cycles with no transfer of any kind and ends the run at STALL_LIMIT.
    initial begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                    || (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random back-pressure, each transfer checked in order
    // ------------------------------------------------------------------
    initial begin
        int unsigned    stall;
        t_charge_report want;
        t_charge_report got;
        i_m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            stall = draw_gap();
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            got.raw_percent      = o_m_axis_tdata[PCT_W-1:0];
            got.filtered_percent = o_m_axis_tdata[2*PCT_W-1:PCT_W];
            got.supply_ok        = o_m_axis_tdata[2*PCT_W];
            if (pending_reports.size() == 0) begin
                $error("result transfer with no reading outstanding: tdata=%h", o_m_axis_tdata);
                error_count++;
            end else begin
                want = pending_reports.pop_front();
                if (got.raw_percent !== want.raw_percent) begin
                    $error("raw_percent: expected %0d, got %0d",
                           want.raw_percent, got.raw_percent);
                    error_count++;
                end
                if (got.filtered_percent !== want.filtered_percent) begin
                    $error("filtered_percent: expected %0d, got %0d",
                           want.filtered_percent, got.filtered_percent);
                    error_count++;
                end
                if (got.supply_ok !== want.supply_ok) begin
                    $error("supply_ok: expected %0d, got %0d",
                           want.supply_ok, got.supply_ok);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sample side and register writes
    // ------------------------------------------------------------------
    // One reading: random gap, then hold tvalid until the transfer. tvalid is
    // left high afterwards so back-to-back readings need no extra edge; the
    // next call or stop_samples decides at the following falling edge.
    task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
        int unsigned gap;
        gap = draw_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{IN_PAD_W{1'b0}}, sample};
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_reports.push_back(predict_report(sample));
    endtask

    // Must follow a send_sample directly, before the next rising edge.
    task automatic stop_samples();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
    endtask

    // Block idle: no reading on the bus and every result returned.
    task automatic drain_results();
        stop_samples();
        wait (pending_reports.size() == 0);
        @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [MV_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == REG_EMPTY_MV)
            empty_mv = value;
        else if (index == REG_FULL_MV)
            full_mv = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset thresholds: first reading primes the history, a run of empty
    // readings moves the filtered value and drops supply_ok, a full one restores it.
    task automatic test_priming_and_power_loss();
        send_sample(SAMPLE_W'(900));
        send_sample(SAMPLE_W'(900));
        repeat (6) send_sample('0);
        send_sample('1);
        drain_results();
    endtask

    // Narrow window 4200..4284 mV: reading exactly at empty (0 %, not low),
    // just below it, a mid value, exactly at full and the top code.
    // Writes to the unmapped indexes must leave the thresholds alone.
    task automatic test_register_map();
        write_register(REG_EMPTY_MV, MV_W'(4200));
        write_register(REG_FULL_MV, MV_W'(4284));
        send_sample(SAMPLE_W'(1000));
        send_sample(SAMPLE_W'(999));
        send_sample(SAMPLE_W'(1010));
        send_sample(SAMPLE_W'(1020));
        send_sample(SAMPLE_W'(1023));
        drain_results();
        write_register(REG_SPARE_A, MV_W'($urandom));
        write_register(REG_SPARE_B, MV_W'($urandom));
        send_sample(SAMPLE_W'(1010));
        drain_results();
    endtask

    // Full at or below empty: the percentage becomes a plain threshold on full.
    task automatic test_inverted_thresholds();
        write_register(REG_EMPTY_MV, MV_W'(4284));
        write_register(REG_FULL_MV, MV_W'(4200));
        send_sample(SAMPLE_W'(1000));
        send_sample(SAMPLE_W'(999));
        drain_results();
        write_register(REG_EMPTY_MV, MV_W'(4200));
        send_sample(SAMPLE_W'(1000));
        send_sample(SAMPLE_W'(999));
        drain_results();
    endtask

    // Register extremes, including values above the nominal range.
    task automatic test_register_extremes();
        write_register(REG_EMPTY_MV, '0);
        write_register(REG_FULL_MV, '1);
        send_sample('1);
        send_sample('0);
        drain_results();
        write_register(REG_EMPTY_MV, '1);
        write_register(REG_FULL_MV, '0);
        send_sample('0);
        send_sample('1);
        drain_results();
    endtask

    // Random phases over several threshold settings. Readings come in runs
    // of repeated codes around the thresholds so that the debounce and the
    // low-run counter both trip, with sprinkled noise and isolated values.
    task automatic test_random_readings();
        int unsigned e_pick;
        int unsigned sent;
        int unsigned run_len;
        int          centre;
        int          base;
        logic [SAMPLE_W-1:0] sample;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin
                    write_register(REG_EMPTY_MV, EMPTY_MV_RST);
                    write_register(REG_FULL_MV, FULL_MV_RST);
                end
                1: begin
                    write_register(REG_EMPTY_MV, '0);
                    write_register(REG_FULL_MV, MV_W'(4297));
                end
                2: begin
                    write_register(REG_EMPTY_MV, MV_W'(4297));
                    write_register(REG_FULL_MV, '0);
                end
                3: begin
                    e_pick = $urandom_range(0, 4200);
                    write_register(REG_EMPTY_MV, MV_W'(e_pick));
                    write_register(REG_FULL_MV, MV_W'(e_pick + $urandom_range(1, 60)));
                end
                4: begin
                    e_pick = $urandom_range(0, 4297);
                    write_register(REG_EMPTY_MV, MV_W'(e_pick));
                    write_register(REG_FULL_MV, MV_W'(e_pick));
                end
                5, 8: begin
                    write_register(REG_EMPTY_MV, MV_W'($urandom_range(0, 4297)));
                    write_register(REG_FULL_MV, MV_W'($urandom_range(0, 4297)));
                end
                6: begin
                    write_register(REG_EMPTY_MV, '0);
                    write_register(REG_FULL_MV, '0);
                end
                7: begin
                    write_register(REG_EMPTY_MV, '1);
                    write_register(REG_FULL_MV, MV_W'($urandom));
                end
                default: begin
                    write_register(REG_EMPTY_MV, MV_W'(3000));
                    write_register(REG_FULL_MV, MV_W'(4297));
                end
            endcase
            if ($urandom_range(0, 2) == 0)
                write_register($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, MV_W'($urandom));
            sent = 0;
            while (sent < READINGS_PER_PHASE) begin
                // occasional stretch with no idling on either side
                if (sent % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
                case ($urandom_range(0, 9))
                    0, 1, 2: centre = (empty_mv * 10) / 42;
                    3, 4:    centre = (full_mv * 10) / 42;
                    5, 6:    centre = (empty_mv * 5 + full_mv * 5) / 42;
                    default: centre = $urandom_range(0, 1023);
                endcase
                base = centre + $urandom_range(0, 40) - 20;
                if (base < 0) base = 0;
                if (base > 1023) base = 1023;
                run_len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 10);
                for (int k = 0; k < run_len && sent < READINGS_PER_PHASE; k++) begin
                    sample = SAMPLE_W'(base);
                    if ($urandom_range(0, 9) == 0)
                        sample = SAMPLE_W'($urandom);
                    else if ($urandom_range(0, 9) == 0)
                        sample = sample + SAMPLE_W'($urandom_range(0, 2)) - SAMPLE_W'(1);
                    send_sample(sample);
                    sent++;
                end
            end
            no_gaps = 1'b0;
            drain_results();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_priming_and_power_loss();
        test_register_map();
        test_inverted_thresholds();
        test_register_extremes();
        test_random_readings();

        // anything extra from the block would show up in the tail
        wait (pending_reports.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_reports.size() != 0) begin
            $error("%0d results never arrived", pending_reports.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// File: battery_percent_stable_filter.f
+incdir+rtl
rtl/bpsf_pkg.sv
rtl/bpsf_div.sv
rtl/battery_percent_stable_filter.sv
tb/sv/battery_percent_stable_filter_test.sv
